// ----- hdl/rcu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcu_pkg
// Shared types, constants and the control store of the radix converter.
// ----------------------------------------------------------------------------
package rcu_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;

  localparam int ACC_W  = VALUE_WIDTH - 1;
  localparam int BASE_W = 6;
  localparam int CHAR_W = 8;
  localparam int DIG_W  = 4;
  localparam int DIG_AW = $clog2(MAX_DIGITS);
  localparam int DIG_CW = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CW = $clog2(ACC_W);

  localparam logic CFG_IN_BASE  = 1'b0;
  localparam logic CFG_OUT_BASE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_BASE  = 3'd1,
    ST_BAD_DIGIT = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_ZERO      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_ACCUM,
    OP_CHECK,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_STORE,
    OP_OVCHK,
    OP_READ,
    OP_EMIT_DG,
    OP_EMIT_ST
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NEVER,
    C_NOT_LAST,
    C_BAD,
    C_DIV_MORE,
    C_MORE,
    C_V_NZ,
    C_N_NZ
  } cond_e;

  typedef enum logic [3:0] {
    S_WAIT     = 4'd0,
    S_ACCUM    = 4'd1,
    S_CHECK    = 4'd2,
    S_DIVINIT  = 4'd3,
    S_DIVSTEP  = 4'd4,
    S_STORE    = 4'd5,
    S_OVCHK    = 4'd6,
    S_READ     = 4'd7,
    S_EMIT_DG  = 4'd8,
    S_RESTART  = 4'd9,
    S_EMIT_ST  = 4'd10
  } step_e;

  typedef struct packed {
    logic  wait_in;
    logic  wait_out;
    op_e   op;
    cond_e cond;
    step_e target;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    logic fire;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic last;
    logic bad;
    logic div_more;
    logic more;
    logic v_nz;
    logic n_nz;
  } flags_t;

  function automatic ucode_t ucode_rom(step_e step);
    ucode_t w;
    w = '{wait_in: 1'b0, wait_out: 1'b0, op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
    case (step)
      S_WAIT:    w = '{1'b1, 1'b0, OP_LATCH,   C_NEVER,    S_WAIT};
      S_ACCUM:   w = '{1'b0, 1'b0, OP_ACCUM,   C_NOT_LAST, S_WAIT};
      S_CHECK:   w = '{1'b0, 1'b0, OP_CHECK,   C_BAD,      S_EMIT_ST};
      S_DIVINIT: w = '{1'b0, 1'b0, OP_DIVINIT, C_NEVER,    S_WAIT};
      S_DIVSTEP: w = '{1'b0, 1'b0, OP_DIVSTEP, C_DIV_MORE, S_DIVSTEP};
      S_STORE:   w = '{1'b0, 1'b0, OP_STORE,   C_MORE,     S_DIVINIT};
      S_OVCHK:   w = '{1'b0, 1'b0, OP_OVCHK,   C_V_NZ,     S_EMIT_ST};
      S_READ:    w = '{1'b0, 1'b0, OP_READ,    C_NEVER,    S_WAIT};
      S_EMIT_DG: w = '{1'b0, 1'b1, OP_EMIT_DG, C_N_NZ,     S_READ};
      S_RESTART: w = '{1'b0, 1'b0, OP_NOP,     C_ALWAYS,   S_WAIT};
      S_EMIT_ST: w = '{1'b0, 1'b1, OP_EMIT_ST, C_ALWAYS,   S_WAIT};
      default:   w = '{1'b0, 1'b0, OP_NOP,     C_ALWAYS,   S_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/rcu_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcu_sequencer
// Step counter over the control store, with wait and conditional jumps.
// ----------------------------------------------------------------------------
module rcu_sequencer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rcu_pkg::flags_t flags_i,
  output rcu_pkg::ctrl_t       ctrl_o,
  output logic                 in_stall_o
);

  rcu_pkg::step_e  pc_q, pc_d;
  rcu_pkg::ucode_t uw;
  logic            proceed;
  logic            taken;

  assign uw = rcu_pkg::ucode_rom(pc_q);

  always_comb begin
    proceed = !(uw.wait_in && !flags_i.in_valid) && !(uw.wait_out && !flags_i.out_free);
    case (uw.cond)
      rcu_pkg::C_ALWAYS:   taken = 1'b1;
      rcu_pkg::C_NEVER:    taken = 1'b0;
      rcu_pkg::C_NOT_LAST: taken = !flags_i.last;
      rcu_pkg::C_BAD:      taken = flags_i.bad;
      rcu_pkg::C_DIV_MORE: taken = flags_i.div_more;
      rcu_pkg::C_MORE:     taken = flags_i.more;
      rcu_pkg::C_V_NZ:     taken = flags_i.v_nz;
      rcu_pkg::C_N_NZ:     taken = flags_i.n_nz;
      default:             taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (proceed) begin
      if (taken) begin
        pc_d = uw.target;
      end else begin
        pc_d = rcu_pkg::step_e'(4'(pc_q) + 4'd1);
      end
    end
  end

  always_comb begin
    ctrl_o.op   = uw.op;
    ctrl_o.fire = proceed;
    in_stall_o  = !uw.wait_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= rcu_pkg::S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/rcu_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rcu_datapath
// Accumulator, bit-serial divider, remainder store and output register.
// ----------------------------------------------------------------------------
module rcu_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rcu_pkg::ctrl_t              ctrl_i,
  input  wire logic                        in_valid_i,
  input  wire logic [rcu_pkg::CHAR_W-1:0]  digit_char_i,
  input  wire logic                        last_i,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [rcu_pkg::BASE_W-1:0]  cfg_data_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic [rcu_pkg::CHAR_W-1:0]       out_char_o,
  output logic [2:0]                       status_o,
  output logic                             out_last_o,
  output rcu_pkg::flags_t                  flags_o
);

  localparam int PROD_W = rcu_pkg::ACC_W + rcu_pkg::BASE_W;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_Z = 8'h5A;
  localparam logic [6:0] NO_DIGIT = 7'd64;

  function automatic logic [6:0] char_value(logic [7:0] c);
    logic [6:0] r;
    r = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      r = 7'(c - CH_0);
    end else if (c >= CH_A && c <= CH_Z) begin
      r = 7'(c - CH_A) + 7'd10;
    end
    return r;
  endfunction

  logic [rcu_pkg::BASE_W-1:0]  in_base_q, out_base_q;
  logic [rcu_pkg::ACC_W-1:0]   acc_q, acc_d;
  rcu_pkg::status_e            err_q, err_d;
  rcu_pkg::status_e            st_q, st_d, st_now;
  logic [rcu_pkg::CHAR_W-1:0]  char_q;
  logic                        last_q;
  logic [rcu_pkg::ACC_W-1:0]   v_q, v_d;
  logic [rcu_pkg::DIG_W-1:0]   rem_q, rem_d;
  logic [rcu_pkg::BIT_CW-1:0]  bit_q, bit_d;
  logic [rcu_pkg::DIG_CW-1:0]  n_q, n_d;
  logic [rcu_pkg::DIG_W-1:0]   mem [rcu_pkg::MAX_DIGITS];
  logic [rcu_pkg::DIG_W-1:0]   rd_q;
  logic [rcu_pkg::DIG_AW-1:0]  rd_addr;

  logic                        ov_q, ov_d;
  logic [rcu_pkg::CHAR_W-1:0]  oc_q, oc_d;
  logic [2:0]                  os_q, os_d;
  logic                        ol_q, ol_d;
  logic                        out_free;

  logic [6:0]                  dval;
  logic [PROD_W-1:0]           prod;
  logic [4:0]                  trial;
  logic                        qbit;
  logic [4:0]                  diff;
  logic                        fire;

  assign fire     = ctrl_i.fire;
  assign out_free = !ov_q || !out_stall_i;
  assign rd_addr  = rcu_pkg::DIG_AW'(n_q - rcu_pkg::DIG_CW'(1));

  always_comb begin
    dval  = char_value(char_q);
    prod  = PROD_W'(acc_q) * PROD_W'(in_base_q) + PROD_W'(dval);
    trial = {rem_q, v_q[rcu_pkg::ACC_W-1]};
    qbit  = trial >= out_base_q[4:0];
    diff  = trial - out_base_q[4:0];
    if (err_q != rcu_pkg::ST_OK) begin
      st_now = err_q;
    end else if (out_base_q < 6'd2 || out_base_q > 6'd16) begin
      st_now = rcu_pkg::ST_BAD_BASE;
    end else if (acc_q == '0) begin
      st_now = rcu_pkg::ST_ZERO;
    end else begin
      st_now = rcu_pkg::ST_OK;
    end
  end

  always_comb begin
    acc_d = acc_q;
    err_d = err_q;
    st_d  = st_q;
    v_d   = v_q;
    rem_d = rem_q;
    bit_d = bit_q;
    n_d   = n_q;
    ov_d  = ov_q && out_stall_i;
    oc_d  = oc_q;
    os_d  = os_q;
    ol_d  = ol_q;
    if (fire) begin
      case (ctrl_i.op)
        rcu_pkg::OP_ACCUM: begin
          if (err_q == rcu_pkg::ST_OK) begin
            if (dval >= {1'b0, in_base_q}) begin
              err_d = rcu_pkg::ST_BAD_DIGIT;
            end else if (prod[PROD_W-1:rcu_pkg::ACC_W] != '0) begin
              err_d = rcu_pkg::ST_OVERFLOW;
            end else begin
              acc_d = prod[rcu_pkg::ACC_W-1:0];
            end
          end
        end
        rcu_pkg::OP_CHECK: begin
          st_d  = st_now;
          v_d   = acc_q;
          n_d   = '0;
          acc_d = '0;
          err_d = rcu_pkg::ST_OK;
        end
        rcu_pkg::OP_DIVINIT: begin
          rem_d = '0;
          bit_d = '0;
        end
        rcu_pkg::OP_DIVSTEP: begin
          rem_d = qbit ? diff[3:0] : trial[3:0];
          v_d   = {v_q[rcu_pkg::ACC_W-2:0], qbit};
          bit_d = bit_q + rcu_pkg::BIT_CW'(1);
        end
        rcu_pkg::OP_STORE: begin
          n_d = n_q + rcu_pkg::DIG_CW'(1);
        end
        rcu_pkg::OP_OVCHK: begin
          st_d = rcu_pkg::ST_OVERFLOW;
        end
        rcu_pkg::OP_READ: begin
          n_d = n_q - rcu_pkg::DIG_CW'(1);
        end
        rcu_pkg::OP_EMIT_DG: begin
          ov_d = 1'b1;
          oc_d = (rd_q < 4'd10) ? (CH_0 + 8'(rd_q)) : (CH_A + 8'(rd_q) - 8'd10);
          os_d = rcu_pkg::ST_OK;
          ol_d = n_q == '0;
        end
        rcu_pkg::OP_EMIT_ST: begin
          ov_d = 1'b1;
          oc_d = '0;
          os_d = st_q;
          ol_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_base_q  <= 6'd10;
      out_base_q <= 6'd10;
      acc_q      <= '0;
      err_q      <= rcu_pkg::ST_OK;
      st_q       <= rcu_pkg::ST_OK;
      bit_q      <= '0;
      n_q        <= '0;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rcu_pkg::CFG_IN_BASE) begin
          in_base_q <= cfg_data_i;
        end else begin
          out_base_q <= cfg_data_i;
        end
      end
      acc_q <= acc_d;
      err_q <= err_d;
      st_q  <= st_d;
      bit_q <= bit_d;
      n_q   <= n_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && ctrl_i.op == rcu_pkg::OP_LATCH) begin
      char_q <= digit_char_i;
      last_q <= last_i;
    end
    if (fire && ctrl_i.op == rcu_pkg::OP_STORE) begin
      mem[n_q[rcu_pkg::DIG_AW-1:0]] <= rem_q;
    end
    if (fire && ctrl_i.op == rcu_pkg::OP_READ) begin
      rd_q <= mem[rd_addr];
    end
    v_q   <= v_d;
    rem_q <= rem_d;
    oc_q  <= oc_d;
    os_q  <= os_d;
    ol_q  <= ol_d;
  end

  always_comb begin
    flags_o.in_valid = in_valid_i;
    flags_o.out_free = out_free;
    flags_o.last     = last_q;
    flags_o.bad      = st_now != rcu_pkg::ST_OK;
    flags_o.div_more = bit_q != rcu_pkg::BIT_CW'(rcu_pkg::ACC_W - 1);
    flags_o.v_nz     = v_q != '0;
    flags_o.more     = (v_q != '0) && (n_q != rcu_pkg::DIG_CW'(rcu_pkg::MAX_DIGITS - 1));
    flags_o.n_nz     = n_q != '0;
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign status_o    = os_q;
  assign out_last_o  = ol_q;

endmodule
`default_nettype wire

// ----- hdl/radix_converter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// radix_converter_unit
// Converts a number given as ASCII digits in one radix to ASCII digits in
// another radix.
// Input channel: one digit character per word, most significant first,
// last_i on the final character. Output channel: one character per word,
// most significant first, out_last_o on the final word; an error or a zero
// value gives a single status word instead. Set bases while the unit is idle.
// Each input character is first accepted, then accumulated. After the final
// character the unit runs the checks; on an error or a zero value a status
// word is then loaded once the output register is free. Otherwise each output
// digit comes from the bit-serial divider (setup, one quotient bit per cycle
// over 31 value bits, store), then a step checks the digit count, each digit
// is read from the remainder store and emitted, and a last step ends the
// number. The input stalls until then.
// The output register holds its word while the receiver stalls; the unit
// waits only when it has a further word to load.
// Reset sets both bases to 10, clears the accumulator and error flag and
// empties the output register.
// ----------------------------------------------------------------------------
module radix_converter_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [rcu_pkg::CHAR_W-1:0]  digit_char_i,
  input  wire logic                        last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [rcu_pkg::CHAR_W-1:0]       out_char_o,
  output logic [2:0]                       status_o,
  output logic                             out_last_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [rcu_pkg::BASE_W-1:0]  cfg_data_i
);

  rcu_pkg::ctrl_t  ctrl;
  rcu_pkg::flags_t flags;

  rcu_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flags_i    (flags),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  rcu_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_valid_i   (in_valid_i),
    .digit_char_i (digit_char_i),
    .last_i       (last_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_char_o   (out_char_o),
    .status_o     (status_o),
    .out_last_o   (out_last_o),
    .flags_o      (flags)
  );

endmodule
`default_nettype wire

// ----- sim/radix_converter_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_converter_unit_tb
// Self-checking bench for the radix converter. Digit words are fed from a
// queue, and the expected result words are predicted when each digit word is
// accepted. They are compared field by field as the unit emits them. A
// directed set of odd bases, bad digits, overflow and zero values comes first.
// Random numbers follow under changing bases, with sender gaps, receiver
// stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module radix_converter_unit_tb;

  localparam int     HOLD_CYCLES   = 1500;
  localparam int     SETTLE_CYCLES = 40;
  localparam longint LIMIT_CYCLES  = 2_500_000;

  localparam logic [rcu_pkg::CHAR_W-1:0] CH_ZERO = "0";
  localparam logic [rcu_pkg::CHAR_W-1:0] CH_NINE = "9";
  localparam logic [rcu_pkg::CHAR_W-1:0] CH_A    = "A";
  localparam logic [rcu_pkg::CHAR_W-1:0] CH_Z    = "Z";

  typedef struct {
    logic [rcu_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_word_t;

  typedef struct {
    logic [rcu_pkg::CHAR_W-1:0] ch;
    rcu_pkg::status_e           st;
    logic                       last;
  } conv_word_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [rcu_pkg::CHAR_W-1:0] digit_char_i = '0;
  logic                       last_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [rcu_pkg::CHAR_W-1:0] out_char_o;
  logic [2:0]                 status_o;
  logic                       out_last_o;
  logic                       cfg_we_i;
  logic                       cfg_idx_i;
  logic [rcu_pkg::BASE_W-1:0] cfg_data_i;

  logic [rcu_pkg::BASE_W-1:0] src_base;
  logic [rcu_pkg::BASE_W-1:0] dst_base;
  logic [rcu_pkg::ACC_W-1:0]  acc_value = '0;
  rcu_pkg::status_e           acc_err = rcu_pkg::ST_OK;

  digit_word_t feed_q[$];
  conv_word_t  conv_q[$];
  digit_word_t feed_word;

  int     snd_idle_pct  = 0;
  int     rcv_stall_pct = 0;
  logic   word_taken    = 1'b0;
  logic   out_hold      = 1'b0;
  logic   pressure_on   = 1'b0;
  int     mismatches    = 0;
  int     words_in      = 0;
  int     words_out     = 0;
  int     settings_run  = 1;
  longint cycle_cnt     = 0;

  radix_converter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .digit_char_i (digit_char_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .status_o     (status_o),
    .out_last_o   (out_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int char_digit(logic [rcu_pkg::CHAR_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_A && c <= CH_Z) return 10 + int'(c - CH_A);
    return 64;
  endfunction

  function automatic logic [rcu_pkg::CHAR_W-1:0] to_ascii(int d);
    return (d < 10) ? rcu_pkg::CHAR_W'(int'(CH_ZERO) + d)
                    : rcu_pkg::CHAR_W'(int'(CH_A) + d - 10);
  endfunction

  function automatic int digits_for(int b);
    longint unsigned v;
    int n;
    v = (longint'(1) << rcu_pkg::ACC_W) - 1;
    n = 0;
    if (b < 2) return 4;
    while (v != 0) begin
      v = v / b;
      n++;
    end
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatches++;
  endtask

  task automatic predict_conversion(input logic [rcu_pkg::CHAR_W-1:0] c, input logic fin);
    longint unsigned v;
    longint unsigned lim;
    int d;
    int n;
    logic [rcu_pkg::DIG_W-1:0] rems [rcu_pkg::MAX_DIGITS];
    rcu_pkg::status_e st;
    conv_word_t w;
    lim = (longint'(1) << rcu_pkg::ACC_W) - 1;
    if (acc_err == rcu_pkg::ST_OK) begin
      d = char_digit(c);
      if (d >= src_base) acc_err = rcu_pkg::ST_BAD_DIGIT;
      else if (acc_value > (lim - d) / src_base) acc_err = rcu_pkg::ST_OVERFLOW;
      else acc_value = rcu_pkg::ACC_W'(acc_value * src_base + d);
    end
    if (!fin) return;
    st = acc_err;
    if (st == rcu_pkg::ST_OK) begin
      if (dst_base < 2 || dst_base > 16) st = rcu_pkg::ST_BAD_BASE;
      else if (acc_value == 0) st = rcu_pkg::ST_ZERO;
    end
    n = 0;
    if (st == rcu_pkg::ST_OK) begin
      v = acc_value;
      while (v != 0 && n < rcu_pkg::MAX_DIGITS) begin
        rems[n] = rcu_pkg::DIG_W'(v % dst_base);
        v = v / dst_base;
        n++;
      end
      if (v != 0) st = rcu_pkg::ST_OVERFLOW;
    end
    acc_value = '0;
    acc_err = rcu_pkg::ST_OK;
    if (st != rcu_pkg::ST_OK) begin
      w.ch = '0;
      w.st = st;
      w.last = 1'b1;
      conv_q.push_back(w);
    end else begin
      for (int k = n - 1; k >= 0; k--) begin
        w.ch = to_ascii(int'(rems[k]));
        w.st = rcu_pkg::ST_OK;
        w.last = (k == 0);
        conv_q.push_back(w);
      end
    end
  endtask

  task automatic check_word();
    conv_word_t w;
    words_out++;
    if (conv_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word char=%h status=%0d last=%b",
                                out_char_o, status_o, out_last_o));
      return;
    end
    w = conv_q.pop_front();
    if (out_char_o !== w.ch)
      report_mismatch($sformatf("out_char %h, want %h", out_char_o, w.ch));
    if (status_o !== w.st)
      report_mismatch($sformatf("status %0d, want %0d", status_o, w.st));
    if (out_last_o !== w.last)
      report_mismatch($sformatf("out_last %b, want %b", out_last_o, w.last));
  endtask

  // sample both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      word_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        words_in++;
        predict_conversion(digit_char_i, last_i);
      end
      if (out_valid_o && !out_stall_i) check_word();
    end
  end

  // hold the word until taken, then advance
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      if (feed_q.size() != 0 && $urandom_range(99, 0) >= snd_idle_pct) begin
        feed_word = feed_q.pop_front();
        in_valid_i <= 1'b1;
        digit_char_i <= feed_word.ch;
        last_i <= feed_word.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= out_hold || ($urandom_range(99, 0) < rcv_stall_pct);
  end

  initial begin
    wait (pressure_on);
    @(posedge clk_i);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    out_hold <= 1'b0;
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk_i);
    $display("Run timed out after %0d cycles", cycle_cnt);
    $display("Mismatches found");
    $finish;
  end

  task automatic push_word(input logic [rcu_pkg::CHAR_W-1:0] ch, input logic fin);
    digit_word_t w;
    w.ch = ch;
    w.last = fin;
    feed_q.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    while (feed_q.size() != 0 || in_valid_i || conv_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_bases(input logic [rcu_pkg::BASE_W-1:0] in_b,
                           input logic [rcu_pkg::BASE_W-1:0] out_b);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= rcu_pkg::CFG_IN_BASE;
    cfg_data_i <= in_b;
    src_base = in_b;
    @(negedge clk_i);
    cfg_idx_i <= rcu_pkg::CFG_OUT_BASE;
    cfg_data_i <= out_b;
    dst_base = out_b;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_run++;
  endtask

  task automatic push_random_number(output int counted);
    int kind;
    int len;
    int pos;
    int top;
    int full;
    logic [rcu_pkg::CHAR_W-1:0] ch;
    kind = int'($urandom_range(99, 0));
    top = (src_base > 36) ? 36 : int'(src_base);
    full = digits_for(int'(src_base));
    if (kind >= 90) begin
      len = int'($urandom_range(4, 1));
      for (int i = 0; i < len; i++)
        push_word(rcu_pkg::CHAR_W'($urandom_range(255, 0)), i == len - 1);
      counted = len;
      return;
    end
    if (kind < 10) len = int'($urandom_range(full + 1, (full > 1) ? full - 1 : 1));
    else len = int'($urandom_range(6, 1));
    pos = (kind >= 75) ? int'($urandom_range(len - 1, 0)) : -1;
    for (int i = 0; i < len; i++) begin
      ch = (top == 0) ? CH_ZERO : to_ascii(int'($urandom_range(top - 1, 0)));
      if (i == pos) ch = rcu_pkg::CHAR_W'($urandom_range(255, 0));
      push_word(ch, i == len - 1);
    end
    counted = len;
  endtask

  task automatic fill_random(input int budget);
    int used;
    while (budget > 0) begin
      push_random_number(used);
      budget -= used;
    end
  endtask

  task automatic run_random(input logic [rcu_pkg::BASE_W-1:0] in_b,
                            input logic [rcu_pkg::BASE_W-1:0] out_b,
                            input int snd, input int rcv, input int budget);
    drain();
    set_bases(in_b, out_b);
    snd_idle_pct = snd;
    rcv_stall_pct = rcv;
    fill_random(budget);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = rcu_pkg::CFG_IN_BASE;
    cfg_data_i = '0;
    src_base = 6'd10;
    dst_base = 6'd10;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset bases: zero, lowercase then valid digit, byte extremes, plain value
    push_text("0");
    push_text("a9");
    push_word(8'h00, 1'b1);
    push_word(8'hFF, 1'b1);
    push_text("127");
    drain();
    set_bases(6'd36, 6'd16);
    push_text("ZZZZZZ0");
    push_text("ZZZZ");
    drain();
    set_bases(6'd0, 6'd17);
    push_text("0");
    drain();
    set_bases(6'd1, 6'd0);
    push_text("00");
    push_text("1");
    drain();
    set_bases(6'd63, 6'd2);
    push_text("Z");
    push_text("ZZ");

    run_random(6'd10, 6'd10, 0, 0, 24);
    run_random(6'd16, 6'd2, 49, 0, 24);
    run_random(6'd2, 6'd16, 0, 49, 24);
    run_random(6'd36, 6'd8, 22, 22, 24);

    // fill the unit while the output is held off
    drain();
    set_bases(6'd16, 6'd16);
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    pressure_on = 1'b1;
    fill_random(24);

    run_random(rcu_pkg::BASE_W'($urandom_range(36, 2)),
               rcu_pkg::BASE_W'($urandom_range(16, 2)), 22, 22, 24);
    run_random(rcu_pkg::BASE_W'($urandom_range(63, 0)),
               rcu_pkg::BASE_W'($urandom_range(63, 0)), 49, 0, 24);
    run_random(6'd7, 6'd3, 0, 49, 24);
    drain();

    $display("Run covered %0d digit words in and %0d result words out", words_in, words_out);
    $display("over %0d base settings, with sender gaps, receiver stalls and a long hold-off",
             settings_run);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
